// ----- rtl/tlg_pkg.sv -----
// ----------------------------------------------------------------------------
// Toroidal life generation package
// Shared sizes, types and codes for the grid engine and its row update logic.
// ----------------------------------------------------------------------------
package tlg_pkg;

  localparam int MaxCols  = 64;
  localparam int MaxRows  = 64;
  localparam int ColW     = 6;
  localparam int RowW     = 6;
  localparam int SizeW    = 7;
  localparam int CntW     = 4;
  localparam int AddrW    = RowW + 1;
  localparam int RamDepth = 2 * MaxRows;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam int RegIdxBit = 2;

  localparam logic [CntW-1:0] BirthCount   = CntW'(3);
  localparam logic [CntW-1:0] SurviveCount = CntW'(2);

  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef logic [MaxCols-1:0] row_t;
  typedef logic [ColW-1:0]    col_t;
  typedef logic [RowW-1:0]    rowidx_t;
  typedef logic [SizeW-1:0]   size_t;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_ADVANCE = 2'd1,
    REQ_READ    = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_e;

  typedef struct packed {
    row_t  up;
    row_t  mid;
    row_t  dn;
    size_t width;
    logic  active;
  } row_win_t;

endpackage

// ----- rtl/tlg_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tlg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/tlg_row_update.sv -----
// ----------------------------------------------------------------------------
// Life row update
// Computes the next generation of one grid row from the rows above, at and
// below it, wrapping columns at the configured width.
// ----------------------------------------------------------------------------
module tlg_row_update (
  input  tlg_pkg::row_win_t win_i,
  output tlg_pkg::row_t     row_o
);

  logic [tlg_pkg::SizeW-1:0] wm1_full;
  tlg_pkg::col_t             wm1;
  tlg_pkg::row_t             up_l, up_r, mid_l, mid_r, dn_l, dn_r;
  logic [tlg_pkg::CntW-1:0]  cnt [tlg_pkg::MaxCols];

  function automatic tlg_pkg::row_t left_of(tlg_pkg::row_t r, tlg_pkg::col_t last);
    left_of = {r[tlg_pkg::MaxCols-2:0], r[last]};
  endfunction

  function automatic tlg_pkg::row_t right_of(tlg_pkg::row_t r, tlg_pkg::col_t last);
    tlg_pkg::row_t res;
    res       = {r[0], r[tlg_pkg::MaxCols-1:1]};
    res[last] = r[0];
    right_of  = res;
  endfunction

  assign wm1_full = win_i.width - tlg_pkg::SizeW'(1);
  assign wm1      = wm1_full[tlg_pkg::ColW-1:0];

  assign up_l  = left_of(win_i.up, wm1);
  assign up_r  = right_of(win_i.up, wm1);
  assign mid_l = left_of(win_i.mid, wm1);
  assign mid_r = right_of(win_i.mid, wm1);
  assign dn_l  = left_of(win_i.dn, wm1);
  assign dn_r  = right_of(win_i.dn, wm1);

  always_comb begin
    for (int c = 0; c < tlg_pkg::MaxCols; c++) begin
      cnt[c] = tlg_pkg::CntW'(up_l[c]) + tlg_pkg::CntW'(win_i.up[c]) +
               tlg_pkg::CntW'(up_r[c]) + tlg_pkg::CntW'(mid_l[c]) +
               tlg_pkg::CntW'(mid_r[c]) + tlg_pkg::CntW'(dn_l[c]) +
               tlg_pkg::CntW'(win_i.dn[c]) + tlg_pkg::CntW'(dn_r[c]);
      if (win_i.active && (tlg_pkg::SizeW'(c) < win_i.width)) begin
        row_o[c] = (cnt[c] == tlg_pkg::BirthCount) ||
                   (win_i.mid[c] && (cnt[c] == tlg_pkg::SurviveCount));
      end else begin
        row_o[c] = win_i.mid[c];
      end
    end
  end

endmodule

// ----- rtl/toroidal_life_generation.sv -----
// ----------------------------------------------------------------------------
// Toroidal life generation engine
// Grid of one-bit cells on a torus: write a cell, read a cell, or advance
// the whole grid by one generation. Two grid banks share one row memory.
// ----------------------------------------------------------------------------
// An in-range write reads the row and writes it back; an in-range read reads
// the row and selects the cell; an out-of-range access or unused code goes
// straight to the result. An advance reads three rows and writes one for each
// of all 64 rows through the single read port of the row memory; one item at
// a time. After reset all 64 rows of the live bank are cleared with in_ready_o
// low; configuration writes are taken during that time.
module toroidal_life_generation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     req_type_i,
  input  logic [tlg_pkg::RowW-1:0]       row_i,
  input  logic [tlg_pkg::ColW-1:0]       col_i,
  input  logic                           cell_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           cell_out_o,
  output logic                           in_range_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlg_pkg::ApbAddrW-1:0]   paddr,
  input  logic [tlg_pkg::ApbDataW-1:0]   pwdata,
  output logic [tlg_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);

  typedef enum logic [10:0] {
    ST_CLEAR   = 11'b00000000001,
    ST_IDLE    = 11'b00000000010,
    ST_WR_RD   = 11'b00000000100,
    ST_WR_WB   = 11'b00000001000,
    ST_RD_RD   = 11'b00000010000,
    ST_RD_SEL  = 11'b00000100000,
    ST_ADV_UP  = 11'b00001000000,
    ST_ADV_MID = 11'b00010000000,
    ST_ADV_DN  = 11'b00100000000,
    ST_ADV_WB  = 11'b01000000000,
    ST_DONE    = 11'b10000000000
  } state_e;

  state_e                        state_q, state_d;
  tlg_pkg::rowidx_t              ctr_q, ctr_d;
  logic                          bank_q, bank_d;
  logic                          res_cell_q, res_cell_d;
  logic                          res_range_q, res_range_d;
  tlg_pkg::size_t                width_q, height_q;
  tlg_pkg::size_t                w_eff, h_eff, hm1_full;
  tlg_pkg::rowidx_t              hm1, row_up, row_dn;
  tlg_pkg::rowidx_t              row_q;
  tlg_pkg::col_t                 col_q;
  logic                          cell_q;
  tlg_pkg::row_t                 up_q, mid_q, next_row;
  logic                          out_valid_q, out_cell_q, out_range_q;
  logic                          load_out, in_accept, in_grid;
  logic                          ram_we;
  logic [tlg_pkg::AddrW-1:0]     ram_waddr, ram_raddr;
  tlg_pkg::row_t                 ram_wdata, ram_rdata;
  tlg_pkg::row_win_t             win;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tlg_pkg::SizeW'(tlg_pkg::MaxCols);
      height_q <= tlg_pkg::SizeW'(tlg_pkg::MaxRows);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[tlg_pkg::RegIdxBit])
        tlg_pkg::RegWidth:  width_q  <= pwdata[tlg_pkg::SizeW-1:0];
        tlg_pkg::RegHeight: height_q <= pwdata[tlg_pkg::SizeW-1:0];
        default:            width_q  <= width_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[tlg_pkg::RegIdxBit])
      tlg_pkg::RegWidth:  prdata = tlg_pkg::ApbDataW'(width_q);
      tlg_pkg::RegHeight: prdata = tlg_pkg::ApbDataW'(height_q);
      default:            prdata = '0;
    endcase
  end

  assign w_eff = (width_q > tlg_pkg::SizeW'(tlg_pkg::MaxCols)) ?
                 tlg_pkg::SizeW'(tlg_pkg::MaxCols) : width_q;
  assign h_eff = (height_q > tlg_pkg::SizeW'(tlg_pkg::MaxRows)) ?
                 tlg_pkg::SizeW'(tlg_pkg::MaxRows) : height_q;
  assign hm1_full = h_eff - tlg_pkg::SizeW'(1);
  assign hm1      = hm1_full[tlg_pkg::RowW-1:0];
  assign row_up   = (ctr_q == '0) ? hm1 : ctr_q - tlg_pkg::RowW'(1);
  assign row_dn   = (ctr_q == hm1) ? '0 : ctr_q + tlg_pkg::RowW'(1);

  assign in_grid = (tlg_pkg::SizeW'(row_i) < h_eff) && (tlg_pkg::SizeW'(col_i) < w_eff);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // Row memory: bank in the top address bit, one grid row per entry.
  tlg_ram #(
    .Width (tlg_pkg::MaxCols),
    .Depth (tlg_pkg::RamDepth)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign win = '{up: up_q, mid: mid_q, dn: ram_rdata, width: w_eff,
                 active: (tlg_pkg::SizeW'(ctr_q) < h_eff)};

  tlg_row_update u_row_update (
    .win_i (win),
    .row_o (next_row)
  );

  always_comb begin
    state_d     = state_q;
    ctr_d       = ctr_q;
    bank_d      = bank_q;
    res_cell_d  = res_cell_q;
    res_range_d = res_range_q;
    ram_we      = 1'b0;
    ram_waddr   = {bank_q, row_q};
    ram_wdata   = '0;
    ram_raddr   = {bank_q, row_q};
    load_out    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = {1'b0, ctr_q};
        ctr_d     = ctr_q + tlg_pkg::RowW'(1);
        if (ctr_q == tlg_pkg::RowW'(tlg_pkg::MaxRows - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctr_d      = '0;
          res_cell_d = 1'b0;
          unique case (tlg_pkg::req_e'(req_type_i))
            tlg_pkg::REQ_WRITE: begin
              res_range_d = in_grid;
              state_d     = in_grid ? ST_WR_RD : ST_DONE;
            end
            tlg_pkg::REQ_ADVANCE: begin
              res_range_d = 1'b0;
              state_d     = ST_ADV_UP;
            end
            tlg_pkg::REQ_READ: begin
              res_range_d = in_grid;
              state_d     = in_grid ? ST_RD_RD : ST_DONE;
            end
            default: begin
              res_range_d = 1'b0;
              state_d     = ST_DONE;
            end
          endcase
        end
      end
      ST_WR_RD: begin
        state_d = ST_WR_WB;
      end
      ST_WR_WB: begin
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata & ~(tlg_pkg::row_t'(1) << col_q)) |
                    (tlg_pkg::row_t'(cell_q) << col_q);
        state_d   = ST_DONE;
      end
      ST_RD_RD: begin
        state_d = ST_RD_SEL;
      end
      ST_RD_SEL: begin
        res_cell_d = ram_rdata[col_q];
        state_d    = ST_DONE;
      end
      ST_ADV_UP: begin
        ram_raddr = {bank_q, row_up};
        state_d   = ST_ADV_MID;
      end
      ST_ADV_MID: begin
        ram_raddr = {bank_q, ctr_q};
        state_d   = ST_ADV_DN;
      end
      ST_ADV_DN: begin
        ram_raddr = {bank_q, row_dn};
        state_d   = ST_ADV_WB;
      end
      ST_ADV_WB: begin
        ram_we    = 1'b1;
        ram_waddr = {~bank_q, ctr_q};
        ram_wdata = next_row;
        ctr_d     = ctr_q + tlg_pkg::RowW'(1);
        if (ctr_q == tlg_pkg::RowW'(tlg_pkg::MaxRows - 1)) begin
          bank_d  = ~bank_q;
          state_d = ST_DONE;
        end else begin
          state_d = ST_ADV_UP;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ctr_q       <= '0;
      bank_q      <= 1'b0;
      res_cell_q  <= 1'b0;
      res_range_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      bank_q      <= bank_d;
      res_cell_q  <= res_cell_d;
      res_range_q <= res_range_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      row_q  <= row_i;
      col_q  <= col_i;
      cell_q <= cell_in_i;
    end
    if (state_q == ST_ADV_MID) begin
      up_q <= ram_rdata;
    end
    if (state_q == ST_ADV_DN) begin
      mid_q <= ram_rdata;
    end
    if (load_out) begin
      out_cell_q  <= res_cell_q;
      out_range_q <= res_range_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_out_o  = out_cell_q;
  assign in_range_o  = out_range_q;

  a_we_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR) || (state_q == ST_WR_WB) || (state_q == ST_ADV_WB))
    else $error("grid memory written outside a write state");

  a_adv_other_bank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADV_WB) |-> (ram_waddr[tlg_pkg::AddrW-1] != bank_q))
    else $error("advance wrote into the live bank");

  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("item accepted while another is in progress");

  a_bank_flip : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_q != $past(bank_q)) |-> $past(state_q == ST_ADV_WB))
    else $error("bank changed outside the end of an advance");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Toroidal life generation testbench
// Drives write, read and advance items through the valid/ready input channel
// and checks every result with a cycle-free torus model or typed row values.
// A directed table comes first. Randomized phases follow, each with its own
// APB grid size; all but every third have random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 400000;
  localparam int DirectedRows = 22;
  localparam int NumPhases    = 11;
  localparam int RandPhase    = 9;
  localparam int ItemsPerPhase = 11;
  localparam int DrainCycles  = 300;

  typedef struct packed {
    logic cell_out;
    logic in_range;
  } cell_result_t;

  typedef struct packed {
    tlg_pkg::req_e    req;
    tlg_pkg::rowidx_t row;
    tlg_pkg::col_t    col;
    logic             val;
    logic             typed;
    logic             exp_cell;
    logic             exp_range;
  } stim_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  tlg_pkg::req_e                req_type = tlg_pkg::REQ_WRITE;
  tlg_pkg::rowidx_t             row = '0;
  tlg_pkg::col_t                col = '0;
  logic                         cell_in = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         cell_out;
  logic                         in_range;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [tlg_pkg::ApbAddrW-1:0] paddr = '0;
  logic [tlg_pkg::ApbDataW-1:0] pwdata = '0;
  logic [tlg_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  tlg_pkg::row_t  life_grid [tlg_pkg::MaxRows];
  tlg_pkg::size_t size_w;
  tlg_pkg::size_t size_h;
  cell_result_t   cell_result_q [$];
  logic           quiet = 1'b0;
  int             errors = 0;
  int             results_seen = 0;
  int             cycle_count = 0;
  int             num_writes = 0;
  int             num_reads = 0;
  int             num_advances = 0;

  stim_row_t directed_rows [DirectedRows] = '{
    '{tlg_pkg::REQ_READ,    6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b1},
    '{tlg_pkg::REQ_READ,    6'd63, 6'd63, 1'b0, 1'b1, 1'b0, 1'b1},
    '{tlg_pkg::REQ_WRITE,   6'd0,  6'd0,  1'b1, 1'b1, 1'b0, 1'b1},
    '{tlg_pkg::REQ_READ,    6'd0,  6'd0,  1'b0, 1'b1, 1'b1, 1'b1},
    '{tlg_pkg::REQ_WRITE,   6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b1},
    '{tlg_pkg::REQ_READ,    6'd63, 6'd63, 1'b0, 1'b1, 1'b1, 1'b1},
    '{tlg_pkg::REQ_UNUSED,  6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b0},
    '{tlg_pkg::REQ_ADVANCE, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0, 1'b0},
    '{tlg_pkg::REQ_READ,    6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{tlg_pkg::REQ_WRITE,   6'd10, 6'd10, 1'b1, 1'b1, 1'b0, 1'b1},
    '{tlg_pkg::REQ_WRITE,   6'd10, 6'd11, 1'b1, 1'b1, 1'b0, 1'b1},
    '{tlg_pkg::REQ_WRITE,   6'd10, 6'd12, 1'b1, 1'b1, 1'b0, 1'b1},
    '{tlg_pkg::REQ_ADVANCE, 6'd0,  6'd0,  1'b0, 1'b1, 1'b0, 1'b0},
    '{tlg_pkg::REQ_READ,    6'd9,  6'd11, 1'b0, 1'b0, 1'b0, 1'b0},
    '{tlg_pkg::REQ_READ,    6'd11, 6'd11, 1'b0, 1'b0, 1'b0, 1'b0},
    '{tlg_pkg::REQ_READ,    6'd10, 6'd10, 1'b0, 1'b0, 1'b0, 1'b0},
    '{tlg_pkg::REQ_WRITE,   6'd0,  6'd63, 1'b1, 1'b1, 1'b0, 1'b1},
    '{tlg_pkg::REQ_WRITE,   6'd1,  6'd0,  1'b1, 1'b1, 1'b0, 1'b1},
    '{tlg_pkg::REQ_WRITE,   6'd63, 6'd0,  1'b1, 1'b1, 1'b0, 1'b1},
    '{tlg_pkg::REQ_ADVANCE, 6'd21, 6'd42, 1'b0, 1'b1, 1'b0, 1'b0},
    '{tlg_pkg::REQ_READ,    6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 1'b0},
    '{tlg_pkg::REQ_WRITE,   6'd5,  6'd5,  1'b0, 1'b1, 1'b0, 1'b1}
  };

  int phase_w [NumPhases] = '{0, 5, 1, 2, 3, 127, 64, 1, 8, 0, 64};
  int phase_h [NumPhases] = '{5, 0, 1, 2, 3, 100, 2, 64, 8, 0, 64};

  toroidal_life_generation dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .req_type_i (req_type),
    .row_i      (row),
    .col_i      (col),
    .cell_in_i  (cell_in),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .cell_out_o (cell_out),
    .in_range_o (in_range),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  function automatic int eff_size(tlg_pkg::size_t v, int limit);
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  function automatic void next_generation();
    tlg_pkg::row_t nxt [tlg_pkg::MaxRows];
    int w, h, ru, rd, cl, cr, n;
    w = eff_size(size_w, tlg_pkg::MaxCols);
    h = eff_size(size_h, tlg_pkg::MaxRows);
    if (w == 0 || h == 0) return;
    nxt = life_grid;
    for (int r = 0; r < h; r++) begin
      ru = (r + h - 1) % h;
      rd = (r + 1) % h;
      for (int c = 0; c < w; c++) begin
        cl = (c + w - 1) % w;
        cr = (c + 1) % w;
        n = int'(life_grid[ru][cl]) + int'(life_grid[ru][c]) + int'(life_grid[ru][cr])
          + int'(life_grid[r][cl]) + int'(life_grid[r][cr])
          + int'(life_grid[rd][cl]) + int'(life_grid[rd][c]) + int'(life_grid[rd][cr]);
        nxt[r][c] = (n == int'(tlg_pkg::BirthCount)) ||
                    (life_grid[r][c] && n == int'(tlg_pkg::SurviveCount));
      end
    end
    life_grid = nxt;
  endfunction

  function automatic cell_result_t apply_request(tlg_pkg::req_e req, tlg_pkg::rowidx_t r,
                                                 tlg_pkg::col_t c, logic v);
    cell_result_t res;
    logic hit;
    res = '0;
    hit = (int'(r) < eff_size(size_h, tlg_pkg::MaxRows)) &&
          (int'(c) < eff_size(size_w, tlg_pkg::MaxCols));
    case (req)
      tlg_pkg::REQ_WRITE: begin
        res.in_range = hit;
        if (hit) life_grid[r][c] = v;
      end
      tlg_pkg::REQ_ADVANCE: next_generation();
      tlg_pkg::REQ_READ: begin
        res.in_range = hit;
        if (hit) res.cell_out = life_grid[r][c];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet) return 0;
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_size_reg(logic reg_sel, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tlg_pkg::ApbAddrW'(int'(reg_sel) << tlg_pkg::RegIdxBit);
    pwdata  <= tlg_pkg::ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == tlg_pkg::RegWidth) size_w = tlg_pkg::size_t'(value);
    else size_h = tlg_pkg::size_t'(value);
  endtask

  task automatic send_item(stim_row_t item);
    cell_result_t res;
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= item.req;
    row      <= item.row;
    col      <= item.col;
    cell_in  <= item.val;
    do @(posedge clk_i); while (!in_ready);
    res = apply_request(item.req, item.row, item.col, item.val);
    if (item.typed) begin
      res.cell_out = item.exp_cell;
      res.in_range = item.exp_range;
    end
    cell_result_q.push_back(res);
    case (item.req)
      tlg_pkg::REQ_WRITE:   num_writes++;
      tlg_pkg::REQ_READ:    num_reads++;
      tlg_pkg::REQ_ADVANCE: num_advances++;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (cell_result_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic stim_row_t random_item();
    stim_row_t item;
    int pick, w, h;
    w = eff_size(size_w, tlg_pkg::MaxCols);
    h = eff_size(size_h, tlg_pkg::MaxRows);
    item = '0;
    pick = $urandom_range(0, 99);
    if (pick < 45) item.req = tlg_pkg::REQ_WRITE;
    else if (pick < 80) item.req = tlg_pkg::REQ_READ;
    else if (pick < 94) item.req = tlg_pkg::REQ_ADVANCE;
    else item.req = tlg_pkg::REQ_UNUSED;
    if ($urandom_range(0, 99) < 80 && w > 0 && h > 0) begin
      item.row = tlg_pkg::rowidx_t'($urandom_range(0, h - 1));
      item.col = tlg_pkg::col_t'($urandom_range(0, w - 1));
    end else begin
      item.row = tlg_pkg::rowidx_t'($urandom_range(0, tlg_pkg::MaxRows - 1));
      item.col = tlg_pkg::col_t'($urandom_range(0, tlg_pkg::MaxCols - 1));
    end
    item.val = ($urandom_range(0, 99) < 45);
    return item;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               cell_result_q.size());
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    cell_result_t exp_res;
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (cell_result_q.size() == 0) begin
        $error("unexpected item: cell_out=%0b in_range=%0b", cell_out, in_range);
        errors++;
      end else begin
        exp_res = cell_result_q.pop_front();
        if (cell_out !== exp_res.cell_out) begin
          $error("cell_out: expected %0b, got %0b", exp_res.cell_out, cell_out);
          errors++;
        end
        if (in_range !== exp_res.in_range) begin
          $error("in_range: expected %0b, got %0b", exp_res.in_range, in_range);
          errors++;
        end
      end
    end
  end

  initial begin
    int run;
    int n;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      n = gap_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin
    int w, h;
    for (int r = 0; r < tlg_pkg::MaxRows; r++) life_grid[r] = '0;
    size_w = tlg_pkg::size_t'(tlg_pkg::MaxCols);
    size_h = tlg_pkg::size_t'(tlg_pkg::MaxRows);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    drain_results();

    for (int p = 0; p < NumPhases; p++) begin
      repeat (8) @(posedge clk_i);
      w = phase_w[p];
      h = phase_h[p];
      if (p == RandPhase) begin
        w = $urandom_range(1, 127);
        h = $urandom_range(1, 127);
      end
      write_size_reg(tlg_pkg::RegWidth, w);
      write_size_reg(tlg_pkg::RegHeight, h);
      quiet = (p % 3 == 1);
      for (int i = 0; i < ItemsPerPhase; i++) send_item(random_item());
      drain_results();
    end

    quiet = 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    if (cell_result_q.size() != 0) begin
      $error("%0d expected items never arrived", cell_result_q.size());
      errors++;
    end
    $display("covered %0d writes, %0d reads and %0d advances over %0d grid sizes",
             num_writes, num_reads, num_advances, NumPhases + 1);
    $display("checked %0d result items, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- toroidal_life_generation.f -----
rtl/tlg_pkg.sv
rtl/tlg_ram.sv
rtl/tlg_row_update.sv
rtl/toroidal_life_generation.sv
dv/tb.sv
